// ----- src/clsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_pkg
// Shared constants and types of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

    // Generator moduli and multipliers
    localparam logic [30:0] C_MOD1       = 31'd2147483563;
    localparam logic [30:0] C_MOD2       = 31'd2147483399;
    localparam logic [15:0] C_MUL1       = 16'd40014;
    localparam logic [15:0] C_MUL2       = 16'd40692;
    localparam logic [30:0] C_SEED1_RST  = 31'd1;
    localparam logic [30:0] C_SEED2_RST  = 31'd123456789;

    // 2^31 - modulus, used to fold the high part of a product back in
    localparam logic [7:0]  C_FOLD1      = 8'd85;
    localparam logic [7:0]  C_FOLD2      = 8'd249;

    // 2^32 = 2 * C_MOD1 + C_FRAC_K
    localparam logic [7:0]  C_FRAC_K     = 8'd170;
    localparam logic [31:0] C_FRAC_CAP   = 32'd4294966780;

    // Request command codes
    localparam logic        C_CMD_DRAW   = 1'b0;
    localparam logic        C_CMD_RESEED = 1'b1;

    // Controls from the sequencer to the generator pair
    typedef struct packed {
        logic load;   // take the seed into both generators
        logic mul;    // capture both products
        logic upd1;   // write back the first generator
        logic upd2;   // write back the second generator
    } t_gen_ctl;

endpackage

// ----- src/clsr_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_req_if
// Request channel: command and seed, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clsr_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  command;
    logic [30:0] seed_value;

    modport source (output valid, output command, output seed_value, input ready);
    modport sink   (input valid, input command, input seed_value, output ready);
endinterface

// ----- src/clsr_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_rsp_if
// Result channel: integer and 0.32 fraction, valid/ready handshake.
// ----------------------------------------------------------------------------
interface clsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_int;
    logic [31:0] random_fraction;

    modport source (output valid, output random_int, output random_fraction, input ready);
    modport sink   (input valid, input random_int, input random_fraction, output ready);
endinterface

// ----- src/clsr_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_table
// Shuffle table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clsr_table #(
    parameter  int TABLE_SIZE = 32,
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [30:0]   i_wdata,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [30:0]   o_rdata
);

    logic [30:0]           r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_vld;
    logic [30:0]           r_rdata;

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/clsr_gen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_gen
// Pair of multiplicative congruential generators: product stage, then fold.
// ----------------------------------------------------------------------------
module clsr_gen import clsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_gen_ctl    i_ctl,
    input  logic [30:0] i_seed,
    output logic [30:0] o_g1,
    output logic [30:0] o_g2,
    output logic [30:0] o_g1_next
);

    logic [30:0] r_g1;
    logic [30:0] r_g2;
    logic [46:0] r_p1;
    logic [46:0] r_p2;
    logic [30:0] g2_next;

    // p mod m for m = 2^31 - c: fold the high part, then one subtract
    function automatic logic [30:0] f_fold(input logic [46:0] p, input logic [7:0] c,
                                           input logic [30:0] m);
        logic [31:0] s;
        s = 32'(p[30:0]) + 32'(p[46:31]) * 32'(c);
        if (s >= 32'(m)) begin
            s = s - 32'(m);
        end
        return s[30:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_p1 <= 47'(C_MUL1) * 47'(r_g1);
            r_p2 <= 47'(C_MUL2) * 47'(r_g2);
        end
    end

    assign o_g1_next = f_fold(r_p1, C_FOLD1, C_MOD1);
    assign g2_next   = f_fold(r_p2, C_FOLD2, C_MOD2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1 <= C_SEED1_RST;
            r_g2 <= C_SEED2_RST;
        end else if (i_ctl.load) begin
            r_g1 <= i_seed;
            r_g2 <= i_seed;
        end else begin
            if (i_ctl.upd1) begin
                r_g1 <= o_g1_next;
            end
            if (i_ctl.upd2) begin
                r_g2 <= g2_next;
            end
        end
    end

    assign o_g1 = r_g1;
    assign o_g2 = r_g2;

endmodule

// ----- src/clsr_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_scale
// Slot index and 0.32 fraction of an output; input and partial products are registered.
// ----------------------------------------------------------------------------
module clsr_scale import clsr_pkg::*; #(
    parameter  int TABLE_SIZE = 32,
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
    input  logic          i_clk,
    input  logic [30:0]   i_value,
    output logic [IW-1:0] o_slot,
    output logic [31:0]   o_fraction
);

    localparam longint unsigned LP_D = 64'd1 + (64'd2147483562 / 64'(TABLE_SIZE));
    localparam logic [8:0]      LP_R = 9'((64'd1 << 32) / LP_D);

    logic [30:0] r_v;
    logic [7:0]  r_est;
    logic [38:0] r_t;
    logic [39:0] prod;
    logic [39:0] est_d;
    logic [39:0] rem;
    logic [8:0]  quo;
    logic [7:0]  th;
    logic [31:0] s;
    logic [32:0] frac;

    // Reciprocal estimate is at most one short of the quotient
    assign prod = 40'(i_value) * 40'(LP_R);

    always_ff @(posedge i_clk) begin
        r_v   <= i_value;
        r_est <= prod[39:32];
        r_t   <= 39'(i_value) * 39'(C_FRAC_K);
    end

    assign est_d  = 40'(r_est) * 40'(LP_D);
    assign rem    = 40'(r_v) - est_d;
    assign quo    = 9'(r_est) + 9'(rem >= 40'(LP_D));
    assign o_slot = (quo >= 9'(TABLE_SIZE)) ? IW'(TABLE_SIZE - 1) : quo[IW-1:0];

    // v * 2^32 / m1 = 2v + floor(170 v / m1)
    assign th   = r_t[38:31];
    assign s    = 32'(r_t[30:0]) + 32'(th) * 32'(C_FOLD1);
    assign frac = 33'({r_v, 1'b0}) + 33'(th) + 33'(s >= 32'(C_MOD1));
    assign o_fraction = (frac > 33'(C_FRAC_CAP)) ? C_FRAC_CAP : frac[31:0];

endmodule

// ----- src/combined_lcg_shuffle_rng.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-LCG random number generator with a shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: command 0 draws the next number, command 1
//   reseeds from seed_value (zero counts as one), refills the table and
//   draws. o_rsp returns exactly one result per request: random_int and
//   random_fraction (unsigned 0.32, capped just below one).
//   One request is in work at a time. The products start at the accepting
//   edge; a draw then runs the fold, the table read-modify-write and two
//   scaling stages, and its result lands in the result register. The next
//   request is taken in the following cycle. A reseed holds the block from
//   accept to the next accept: TABLE_SIZE+8 warm-up steps of the first
//   generator, each a multiply and a fold, two scaling stages, then the draw.
//   The result register frees the sequencer: a new request is accepted
//   while a result still waits; the next result holds in the last stage
//   until the receiver takes the pending one.
//   Reset returns both generators and the table to their start values
//   (table reads zero until written); draws before any reseed use them.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng import clsr_pkg::*; #(
    parameter int TABLE_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    clsr_req_if.sink    i_req,
    clsr_rsp_if.source  o_rsp
);

    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = $clog2(TABLE_SIZE + 8);

    typedef enum logic [2:0] {
        S_IDLE,   // wait for a request
        S_WMUL,   // warm-up: multiply
        S_WRED,   // warm-up: fold, fill slot
        S_ISSUE,  // start the draw after warm-up
        S_DRED,   // draw: fold both generators
        S_DMIX,   // draw: combine, write back slot
        S_POST,   // scaling stage one
        S_FIN     // scaling stage two, hand off result
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [IW-1:0]   r_slot;
    logic [30:0]     r_last;
    logic            r_warm;
    logic            r_out_valid;
    logic [30:0]     r_out_int;
    logic [31:0]     r_out_frac;

    t_gen_ctl        gen_ctl;
    logic [30:0]     seed;
    logic [30:0]     g1;
    logic [30:0]     g2;
    logic [30:0]     g1_next;
    logic            tab_we;
    logic [IW-1:0]   tab_waddr;
    logic [30:0]     tab_wdata;
    logic            tab_re;
    logic [30:0]     tab_rdata;
    logic [IW-1:0]   new_slot;
    logic [31:0]     new_frac;
    logic [32:0]     diff;
    logic [32:0]     mix;
    logic            req_fire;
    logic            rsp_free;

    assign req_fire = i_req.valid && i_req.ready;
    assign rsp_free = !r_out_valid || o_rsp.ready;
    assign seed     = (i_req.seed_value == '0) ? 31'd1 : i_req.seed_value;

    // Old slot value minus second generator, wrapped into 1..m1-1
    assign diff = 33'(tab_rdata) - 33'(g2);
    assign mix  = ($signed(diff) < 33'sd1) ? diff + 33'(C_MOD1 - 31'd1) : diff;

    clsr_gen u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (gen_ctl),
        .i_seed    (seed),
        .o_g1      (g1),
        .o_g2      (g2),
        .o_g1_next (g1_next)
    );

    clsr_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_re    (tab_re),
        .i_raddr (r_slot),
        .o_rdata (tab_rdata)
    );

    clsr_scale #(.TABLE_SIZE(TABLE_SIZE)) u_scale (
        .i_clk      (i_clk),
        .i_value    (r_last),
        .o_slot     (new_slot),
        .o_fraction (new_frac)
    );

    // Sequencer controls
    always_comb begin
        gen_ctl   = '0;
        tab_we    = 1'b0;
        tab_waddr = r_slot;
        tab_wdata = g1;
        tab_re    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    // draw: read slot and start products together
                    gen_ctl.load = (i_req.command == C_CMD_RESEED);
                    gen_ctl.mul  = (i_req.command == C_CMD_DRAW);
                    tab_re       = (i_req.command == C_CMD_DRAW);
                end
            end
            S_WMUL: begin
                gen_ctl.mul = 1'b1;
            end
            S_WRED: begin
                gen_ctl.upd1 = 1'b1;
                tab_we       = (r_cnt < CW'(TABLE_SIZE));
                tab_waddr    = r_cnt[IW-1:0];
                tab_wdata    = g1_next;
            end
            S_ISSUE: begin
                gen_ctl.mul = 1'b1;
                tab_re      = 1'b1;
            end
            S_DRED: begin
                gen_ctl.upd1 = 1'b1;
                gen_ctl.upd2 = 1'b1;
            end
            S_DMIX: begin
                // slot takes the first generator's new value
                tab_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_last      <= '0;
            r_warm      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken result unless a new one lands this cycle
            if (o_rsp.ready && !(r_state == S_FIN && !r_warm)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        if (i_req.command == C_CMD_RESEED) begin
                            r_cnt   <= CW'(TABLE_SIZE + 7);
                            r_state <= S_WMUL;
                        end else begin
                            r_state <= S_DRED;
                        end
                    end
                end
                S_WMUL: begin
                    r_state <= S_WRED;
                end
                S_WRED: begin
                    if (r_cnt == '0) begin
                        // last warm-up value seeds the slot pick
                        r_last  <= g1_next;
                        r_warm  <= 1'b1;
                        r_state <= S_POST;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_WMUL;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_DRED;
                end
                S_DRED: begin
                    r_state <= S_DMIX;
                end
                S_DMIX: begin
                    r_last  <= mix[30:0];
                    r_state <= S_POST;
                end
                S_POST: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_warm) begin
                        r_slot  <= new_slot;
                        r_warm  <= 1'b0;
                        r_state <= S_ISSUE;
                    end else if (rsp_free) begin
                        // hand off result, remember next slot
                        r_slot      <= new_slot;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && !r_warm && rsp_free) begin
            r_out_int  <= r_last;
            r_out_frac <= new_frac;
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.random_int      = r_out_int;
    assign o_rsp.random_fraction = r_out_frac;

endmodule
